>>> hdl/sac_pkg.sv
// ---------------------------------------------------------------------------
// sac_pkg: shared types and constants for the set-associative tag/LRU unit
// Field widths of the ports, register indexes, command codes and the
// LFSR step used for pseudo-random victim choice.
// ---------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

  // default geometry
  localparam int WAYS_DEF       = 4;
  localparam int LINE_BITS_DEF  = 4;
  localparam int BLOCK_BITS_DEF = 2;

  // port widths
  localparam int ADDR_W      = 32;
  localparam int BYTE_BITS   = 2;
  localparam int WAY_OUT_W   = 2;
  localparam int LINE_OUT_W  = 4;
  localparam int WORD_OUT_W  = 2;
  localparam int TAG_OUT_W   = 24;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 1;

  // LFSR
  localparam int              LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_REPL    = 2'd2;

  // access commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic write_back;
    logic write_allocate;
    logic random_repl;
  } cfg_t;

  // per-access status from the update logic
  typedef struct packed {
    logic hit;
    logic filled;
    logic victim_valid;
    logic victim_dirty;
    logic row_we;
    logic lfsr_adv;
  } ctl_t;

  // Galois step: shift right, fold in taps when a one falls out
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
    logic [LFSR_W-1:0] s;
    s = x >> 1;
    if (x[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hdl/set_assoc_cache_tag_lru_unit.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_lru_unit: set-associative tag store with LRU/random
// replacement, dirty tracking and saturating hit/miss counters
// ---------------------------------------------------------------------------
// Path: the set row is read at the accept edge into the lookup stage, then
//   compare/update go into the result register; out_stall can hold both.
// Throughput: 1 word per cycle while not stalled; the row RAM is read once and
//   written at most once per access, bypassed for back-to-back same-set access.
// Reset: synchronous; afterwards the unit clears one set row per cycle, all
//   2**LINE_BITS rows (16 by default), with in_stall held high.
`default_nettype none

module set_assoc_cache_tag_lru_unit #(
  parameter int WAYS       = sac_pkg::WAYS_DEF,
  parameter int LINE_BITS  = sac_pkg::LINE_BITS_DEF,
  parameter int BLOCK_BITS = sac_pkg::BLOCK_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sac_pkg::ADDR_W-1:0]       in_address,
  input  wire logic                             in_cmd,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_hit,
  output logic      [sac_pkg::WAY_OUT_W-1:0]    out_way_used,
  output logic      [sac_pkg::LINE_OUT_W-1:0]   out_line_index,
  output logic      [sac_pkg::WORD_OUT_W-1:0]   out_word_index,
  output logic                                  out_filled,
  output logic                                  out_victim_valid,
  output logic                                  out_victim_dirty,
  output logic      [sac_pkg::TAG_OUT_W-1:0]    out_victim_tag,
  output logic      [sac_pkg::CNT_W-1:0]        out_hit_total,
  output logic      [sac_pkg::CNT_W-1:0]        out_miss_total
);

  localparam int WA_W   = sac_pkg::ADDR_W - sac_pkg::BYTE_BITS;
  localparam int TAG_W  = WA_W - BLOCK_BITS - LINE_BITS;
  localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W  = AGE_W;
  localparam int LINE_W = (LINE_BITS > 0) ? LINE_BITS : 1;
  localparam int SETS   = 1 << LINE_BITS;
  localparam int ENT_W  = TAG_W + AGE_W + 2;
  localparam int ROW_W  = WAYS * ENT_W;
  localparam int LFSR_W = sac_pkg::LFSR_W;
  localparam int CNT_W  = sac_pkg::CNT_W;

  localparam logic [31:0] SET_MASK  = 32'((64'd1 << LINE_BITS) - 64'd1);
  localparam logic [31:0] WORD_MASK = 32'((64'd1 << BLOCK_BITS) - 64'd1);
  localparam logic [LINE_W-1:0] LAST_SET = LINE_W'(SETS - 1);

  // reciprocal for x mod WAYS on 16-bit LFSR values
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / WAYS + 64'd1);
  localparam logic [LFSR_W-1:0] LFSR_NX_RST = sac_pkg::lfsr_step(sac_pkg::LFSR_SEED);
  localparam logic [LFSR_W-1:0] LFSR_Q_RST  = LFSR_W'(LFSR_NX_RST / WAYS);

  // configuration
  sac_pkg::cfg_t cfg_r;

  // clearing pass
  logic              clr_busy_r;
  logic [LINE_W-1:0] clr_cnt_r;

  // lookup stage
  logic             s_vld_r;
  logic [WA_W-1:0]  s_addr_r;
  logic             s_cmd_r;

  // row bypass
  logic             byp_vld_r;
  logic [ROW_W-1:0] byp_row_r;

  // LFSR: next value and its quotient by WAYS
  logic [LFSR_W-1:0] lfsr_r, lfsr_q_r;

  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r;

  // result register
  logic                           out_vld_r;
  logic                           o_hit_r, o_filled_r, o_vvalid_r, o_vdirty_r;
  logic [sac_pkg::WAY_OUT_W-1:0]  o_way_r;
  logic [sac_pkg::LINE_OUT_W-1:0] o_line_r;
  logic [sac_pkg::WORD_OUT_W-1:0] o_word_r;
  logic [sac_pkg::TAG_OUT_W-1:0]  o_vtag_r;
  logic [CNT_W-1:0]               o_hit_tot_r, o_miss_tot_r;

  logic              out_free, fire, accept;
  logic [31:0]       in_wa32, s_wa32, s_line32, s_word32, s_tag32, in_line32;
  logic [LINE_W-1:0] s_line, in_line, raddr, waddr;
  logic [TAG_W-1:0]  s_tag;
  logic [ROW_W-1:0]  ram_q, row_cur, row_new, wdata;
  logic              we;
  logic [WAY_W-1:0]  pick, way;
  logic [TAG_W-1:0]  vtag;
  logic [31:0]       way32, vtag32;
  sac_pkg::ctl_t     ctl;
  logic [LFSR_W-1:0] lfsr_nx2;
  logic [48:0]       q_prod;
  logic [LFSR_W+4:0] qd;
  logic [CNT_W-1:0]  hit_cnt_nxt, miss_cnt_nxt;

  // handshake
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = s_vld_r && out_free;
  assign in_stall = clr_busy_r || (s_vld_r && !out_free);
  assign accept   = in_valid && !in_stall;

  // address split
  always_comb begin
    in_wa32   = 32'(in_address[sac_pkg::ADDR_W-1:sac_pkg::BYTE_BITS]);
    in_line32 = (in_wa32 >> BLOCK_BITS) & SET_MASK;
    in_line   = in_line32[LINE_W-1:0];
    s_wa32    = 32'(s_addr_r);
    s_word32  = s_wa32 & WORD_MASK;
    s_line32  = (s_wa32 >> BLOCK_BITS) & SET_MASK;
    s_tag32   = s_wa32 >> (BLOCK_BITS + LINE_BITS);
    s_line    = s_line32[LINE_W-1:0];
    s_tag     = s_tag32[TAG_W-1:0];
  end

  // read the row of the item that sits in the lookup stage next cycle
  assign raddr   = accept ? in_line : s_line;
  assign we      = clr_busy_r || (fire && ctl.row_we);
  assign waddr   = clr_busy_r ? clr_cnt_r : s_line;
  assign wdata   = clr_busy_r ? '0 : row_new;
  assign row_cur = byp_vld_r ? byp_row_r : ram_q;

  sac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // way pick: lfsr_r mod WAYS from the stored quotient
  always_comb begin
    qd   = (LFSR_W+5)'(lfsr_q_r) * (LFSR_W+5)'(WAYS);
    pick = WAY_W'((LFSR_W+5)'(lfsr_r) - qd);
    lfsr_nx2 = sac_pkg::lfsr_step(lfsr_r);
    q_prod   = 49'(lfsr_nx2) * 49'(RECIP);
  end

  sac_update #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .AGE_W (AGE_W),
    .WAY_W (WAY_W)
  ) u_update (
    .row_i  (row_cur),
    .tag_i  (s_tag),
    .cmd_i  (s_cmd_r),
    .cfg_i  (cfg_r),
    .pick_i (pick),
    .row_o  (row_new),
    .way_o  (way),
    .vtag_o (vtag),
    .ctl_o  (ctl)
  );

  // saturating counters
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (ctl.hit && (hit_cnt_r != '1)) begin
      hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end
    if (!ctl.hit && (miss_cnt_r != '1)) begin
      miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
    end
    way32  = 32'(way);
    vtag32 = 32'(vtag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.write_back     <= 1'b1;
      cfg_r.write_allocate <= 1'b1;
      cfg_r.random_repl    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sac_pkg::CFG_WRITE_BACK:     cfg_r.write_back     <= cfg_wdata[0];
        sac_pkg::CFG_WRITE_ALLOCATE: cfg_r.write_allocate <= cfg_wdata[0];
        sac_pkg::CFG_RANDOM_REPL:    cfg_r.random_repl    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + LINE_W'(1);
      if (clr_cnt_r == LAST_SET) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (!s_vld_r || fire) begin
      s_vld_r <= accept;
    end
    if (accept) begin
      s_addr_r <= in_address[sac_pkg::ADDR_W-1:sac_pkg::BYTE_BITS];
      s_cmd_r  <= in_cmd;
    end
  end

  // forward a row written at the same edge it is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else begin
      byp_vld_r <= we && (waddr == raddr);
    end
    byp_row_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r     <= LFSR_NX_RST;
      lfsr_q_r   <= LFSR_Q_RST;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (fire) begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      if (ctl.lfsr_adv) begin
        lfsr_r   <= lfsr_nx2;
        lfsr_q_r <= q_prod[47:32];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
    if (fire) begin
      o_hit_r      <= ctl.hit;
      o_way_r      <= way32[sac_pkg::WAY_OUT_W-1:0];
      o_line_r     <= s_line32[sac_pkg::LINE_OUT_W-1:0];
      o_word_r     <= s_word32[sac_pkg::WORD_OUT_W-1:0];
      o_filled_r   <= ctl.filled;
      o_vvalid_r   <= ctl.victim_valid;
      o_vdirty_r   <= ctl.victim_dirty;
      o_vtag_r     <= vtag32[sac_pkg::TAG_OUT_W-1:0];
      o_hit_tot_r  <= hit_cnt_nxt;
      o_miss_tot_r <= miss_cnt_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_hit          = o_hit_r;
  assign out_way_used     = o_way_r;
  assign out_line_index   = o_line_r;
  assign out_word_index   = o_word_r;
  assign out_filled       = o_filled_r;
  assign out_victim_valid = o_vvalid_r;
  assign out_victim_dirty = o_vdirty_r;
  assign out_victim_tag   = o_vtag_r;
  assign out_hit_total    = o_hit_tot_r;
  assign out_miss_total   = o_miss_tot_r;

endmodule

`default_nettype wire

>>> hdl/sac_ram.sv
// ---------------------------------------------------------------------------
// sac_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/sac_update.sv
// ---------------------------------------------------------------------------
// sac_update: tag compare, victim choice and set row update
// Takes one set row (all ways) and the access, returns the new row and the
// hit, fill and victim status.
// ---------------------------------------------------------------------------
`default_nettype none

module sac_update #(
  parameter int WAYS  = sac_pkg::WAYS_DEF,
  parameter int TAG_W = 24,
  parameter int AGE_W = 2,
  parameter int WAY_W = 2
) (
  input  wire logic [WAYS*(TAG_W+AGE_W+2)-1:0] row_i,
  input  wire logic [TAG_W-1:0]                tag_i,
  input  wire logic                            cmd_i,
  input  wire sac_pkg::cfg_t                   cfg_i,
  input  wire logic [WAY_W-1:0]                pick_i,
  output logic      [WAYS*(TAG_W+AGE_W+2)-1:0] row_o,
  output logic      [WAY_W-1:0]                way_o,
  output logic      [TAG_W-1:0]                vtag_o,
  output sac_pkg::ctl_t                        ctl_o
);

  localparam int ENT_W = TAG_W + AGE_W + 2;
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

  logic             vld [WAYS];
  logic             drt [WAYS];
  logic [AGE_W-1:0] age [WAYS];
  logic [TAG_W-1:0] tg  [WAYS];

  logic [WAYS-1:0]  hit_vec, inv_vec, old_vec;
  logic [WAY_W-1:0] hit_way, inv_way, old_way, vict_way, upd_way;
  logic             any_hit, alloc, dirty_set, touch;
  logic [AGE_W-1:0] prev_age;

  // unpack ways and compare
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tg[w]  = row_i[w*ENT_W +: TAG_W];
      age[w] = row_i[w*ENT_W + TAG_W +: AGE_W];
      drt[w] = row_i[w*ENT_W + TAG_W + AGE_W];
      vld[w] = row_i[w*ENT_W + TAG_W + AGE_W + 1];
      hit_vec[w] = vld[w] && (tg[w] == tag_i);
      inv_vec[w] = !vld[w];
      old_vec[w] = (age[w] == AGE_OLDEST);
    end
  end

  // lowest-numbered way wins
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inv_vec[w]) begin
        inv_way = WAY_W'(w);
      end
      if (old_vec[w]) begin
        old_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    any_hit   = |hit_vec;
    alloc     = !any_hit && ((cmd_i == sac_pkg::CMD_READ) || cfg_i.write_allocate);
    dirty_set = (cmd_i == sac_pkg::CMD_WRITE) && cfg_i.write_back;

    ctl_o.lfsr_adv = 1'b0;
    if (cfg_i.random_repl) begin
      vict_way       = pick_i;
      ctl_o.lfsr_adv = alloc;
    end else if (|inv_vec) begin
      vict_way = inv_way;
    end else if (|old_vec) begin
      vict_way = old_way;
    end else begin
      // ages out of order: fall back to the LFSR
      vict_way       = pick_i;
      ctl_o.lfsr_adv = alloc;
    end

    upd_way  = any_hit ? hit_way : vict_way;
    prev_age = any_hit ? age[hit_way] : AGE_OLDEST;
    touch    = !cfg_i.random_repl && (any_hit || alloc);

    ctl_o.hit          = any_hit;
    ctl_o.filled       = alloc;
    ctl_o.victim_valid = alloc && vld[vict_way];
    ctl_o.victim_dirty = alloc && vld[vict_way] && drt[vict_way];
    ctl_o.row_we       = any_hit || alloc;

    way_o  = (any_hit || alloc) ? upd_way : '0;
    vtag_o = (alloc && vld[vict_way]) ? tg[vict_way] : '0;
  end

  // build the updated row
  always_comb begin
    row_o = '0;
    for (int w = 0; w < WAYS; w++) begin
      logic             sel;
      logic             v_n, d_n;
      logic [AGE_W-1:0] a_n;
      logic [TAG_W-1:0] t_n;
      sel = (WAY_W'(w) == upd_way);
      t_n = (alloc && sel) ? tag_i : tg[w];
      v_n = vld[w] | (alloc && sel);
      if (alloc && sel) begin
        d_n = dirty_set;
      end else if (any_hit && sel && dirty_set) begin
        d_n = 1'b1;
      end else begin
        d_n = drt[w];
      end
      if (touch && sel) begin
        a_n = '0;
      end else if (touch && vld[w] && (age[w] < prev_age)) begin
        a_n = age[w] + AGE_W'(1);
      end else begin
        a_n = age[w];
      end
      row_o[w*ENT_W +: ENT_W] = {v_n, d_n, a_n, t_n};
    end
  end

endmodule

`default_nettype wire

>>> bench/set_assoc_cache_tag_lru_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_lru_unit_tb: self-checking bench for the tag/LRU unit
// Streams read and write accesses into the unit and keeps a shadow copy of
// the valid, dirty, tag and age arrays, the LFSR and both counters. Each
// result word is compared field by field with the access that caused it.
// Covers LRU order, write-through, no write-allocate, random replacement and
// the mixed-mode case, then runs hot-set random traffic under every setting.
// ---------------------------------------------------------------------------
module set_assoc_cache_tag_lru_unit_tb;

  localparam int NUM_WAYS     = 4;
  localparam int NUM_SETS     = 16;
  localparam int NUM_SLOTS    = NUM_WAYS * NUM_SETS;
  localparam logic [15:0] PRNG_FEEDBACK = 16'hB400;
  localparam logic [sac_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int GAP_MAX      = 11;
  localparam int PHASE_WORDS  = 230;
  localparam int TAG_POOL     = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int RUN_LIMIT_NS = 4_000_000;
  localparam int PEND_DEPTH   = 16;

  typedef struct packed {
    logic                           hit;
    logic [sac_pkg::WAY_OUT_W-1:0]  way_used;
    logic [sac_pkg::LINE_OUT_W-1:0] line_index;
    logic [sac_pkg::WORD_OUT_W-1:0] word_index;
    logic                           filled;
    logic                           victim_valid;
    logic                           victim_dirty;
    logic [sac_pkg::TAG_OUT_W-1:0]  victim_tag;
    logic [sac_pkg::CNT_W-1:0]      hit_total;
    logic [sac_pkg::CNT_W-1:0]      miss_total;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [sac_pkg::ADDR_W-1:0] in_address = '0;
  logic in_cmd = sac_pkg::CMD_READ;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [sac_pkg::WAY_OUT_W-1:0] out_way_used;
  logic [sac_pkg::LINE_OUT_W-1:0] out_line_index;
  logic [sac_pkg::WORD_OUT_W-1:0] out_word_index;
  logic out_filled;
  logic out_victim_valid;
  logic out_victim_dirty;
  logic [sac_pkg::TAG_OUT_W-1:0] out_victim_tag;
  logic [sac_pkg::CNT_W-1:0] out_hit_total;
  logic [sac_pkg::CNT_W-1:0] out_miss_total;

  // shadow of the cache state and settings
  bit wb_mode = 1'b1;
  bit alloc_mode = 1'b1;
  bit rand_mode = 1'b0;
  bit slot_valid [NUM_SLOTS];
  bit slot_dirty [NUM_SLOTS];
  bit [sac_pkg::TAG_OUT_W-1:0] slot_tag [NUM_SLOTS];
  bit [1:0] slot_age [NUM_SLOTS];
  bit [15:0] prng = 16'h0001;
  bit [sac_pkg::CNT_W-1:0] hits_seen = '0;
  bit [sac_pkg::CNT_W-1:0] misses_seen = '0;

  // ring of predicted results, oldest at pend_rd
  lookup_result_t pend_buf [PEND_DEPTH];
  int unsigned pend_wr = 0;
  int unsigned pend_rd = 0;
  int unsigned mismatch_count = 0;
  int gap_limit = GAP_MAX;
  int stall_limit = GAP_MAX;
  int stall_left = 0;

  set_assoc_cache_tag_lru_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .in_cmd           (in_cmd),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_way_used     (out_way_used),
    .out_line_index   (out_line_index),
    .out_word_index   (out_word_index),
    .out_filled       (out_filled),
    .out_victim_valid (out_victim_valid),
    .out_victim_dirty (out_victim_dirty),
    .out_victim_tag   (out_victim_tag),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- shadow cache ----------------

  function automatic int next_prng_way();
    prng = {1'b0, prng[15:1]} ^ (prng[0] ? PRNG_FEEDBACK : 16'h0000);
    return int'(prng[1:0]);
  endfunction

  function automatic void age_after_touch(int base, int way, int prev_age);
    int w;
    if (rand_mode) begin
      return;
    end
    for (w = 0; w < NUM_WAYS; w++) begin
      if (slot_valid[base + w] && int'(slot_age[base + w]) < prev_age) begin
        slot_age[base + w] = slot_age[base + w] + 2'd1;
      end
    end
    slot_age[base + way] = 2'd0;
  endfunction

  function automatic int pick_victim(int base);
    int w;
    if (rand_mode) begin
      return next_prng_way();
    end
    for (w = 0; w < NUM_WAYS; w++) begin
      if (!slot_valid[base + w]) begin
        return w;
      end
    end
    for (w = 0; w < NUM_WAYS; w++) begin
      if (slot_age[base + w] == NUM_WAYS - 1) begin
        return w;
      end
    end
    // ages out of order after a random-mode stretch
    return next_prng_way();
  endfunction

  function automatic lookup_result_t predict_lookup(logic [sac_pkg::ADDR_W-1:0] addr,
                                                    logic cmd);
    lookup_result_t r;
    logic [sac_pkg::TAG_OUT_W-1:0] tag;
    int base;
    int way;
    int w;
    bit is_write;
    r = '0;
    tag = addr[31:8];
    r.line_index = addr[7:4];
    r.word_index = addr[3:2];
    is_write = (cmd == sac_pkg::CMD_WRITE);
    base = int'(addr[7:4]) * NUM_WAYS;
    way = 0;
    for (w = 0; w < NUM_WAYS; w++) begin
      if (!r.hit && slot_valid[base + w] && slot_tag[base + w] == tag) begin
        r.hit = 1'b1;
        way = w;
      end
    end
    if (r.hit) begin
      if (hits_seen != '1) begin
        hits_seen = hits_seen + 1;
      end
      if (is_write && wb_mode) begin
        slot_dirty[base + way] = 1'b1;
      end
      age_after_touch(base, way, int'(slot_age[base + way]));
    end else begin
      if (misses_seen != '1) begin
        misses_seen = misses_seen + 1;
      end
      if (!is_write || alloc_mode) begin
        way = pick_victim(base);
        r.filled = 1'b1;
        if (slot_valid[base + way]) begin
          r.victim_valid = 1'b1;
          r.victim_dirty = slot_dirty[base + way];
          r.victim_tag = slot_tag[base + way];
        end
        slot_valid[base + way] = 1'b1;
        slot_dirty[base + way] = is_write && wb_mode;
        slot_tag[base + way] = tag;
        // a fill ages like a hit on the oldest way
        age_after_touch(base, way, NUM_WAYS - 1);
      end
    end
    r.way_used = way[1:0];
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 60) begin
      $display("%0t: MISMATCH %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pend_wr == pend_rd) begin
        report_mismatch("result word with no access pending");
      end else begin
        want = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        check_field("hit", out_hit, want.hit);
        check_field("way_used", out_way_used, want.way_used);
        check_field("line_index", out_line_index, want.line_index);
        check_field("word_index", out_word_index, want.word_index);
        check_field("filled", out_filled, want.filled);
        check_field("victim_valid", out_victim_valid, want.victim_valid);
        check_field("victim_dirty", out_victim_dirty, want.victim_dirty);
        check_field("victim_tag", out_victim_tag, want.victim_tag);
        check_field("hit_total", out_hit_total, want.hit_total);
        check_field("miss_total", out_miss_total, want.miss_total);
      end
    end
  end

  // draw a stall for the next result word once one is taken
  always @(posedge clk) begin
    int hold;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left != 1);
    end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
      hold = $urandom_range(stall_limit);
      stall_left <= hold;
      out_stall <= (hold != 0);
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_access(input logic [sac_pkg::ADDR_W-1:0] addr, input logic cmd);
    int gap;
    in_valid <= 1'b1;
    in_address <= addr;
    in_cmd <= cmd;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    pend_buf[pend_wr % PEND_DEPTH] = predict_lookup(addr, cmd);
    pend_wr++;
    gap = $urandom_range(gap_limit);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pend_wr != pend_rd) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it
  task automatic cfg_put(input logic [sac_pkg::CFG_IDX_W-1:0] idx, input bit val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sac_pkg::CFG_WRITE_BACK: begin
        wb_mode = val;
      end
      sac_pkg::CFG_WRITE_ALLOCATE: begin
        alloc_mode = val;
      end
      sac_pkg::CFG_RANDOM_REPL: begin
        rand_mode = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_mode(input bit wb, input bit wa, input bit rr);
    cfg_put(sac_pkg::CFG_WRITE_BACK, wb);
    cfg_put(sac_pkg::CFG_WRITE_ALLOCATE, wa);
    cfg_put(sac_pkg::CFG_RANDOM_REPL, rr);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [sac_pkg::ADDR_W-1:0] make_addr(logic [23:0] tag,
                                                           logic [3:0] line,
                                                           logic [1:0] word);
    return {tag, line, word, 2'($urandom)};
  endfunction

  task automatic test_lru_order();
    set_mode(1'b1, 1'b1, 1'b0);
    send_access(32'h0000_0000, sac_pkg::CMD_READ);
    send_access(32'hFFFF_FFFF, sac_pkg::CMD_WRITE);
    send_access(32'hFFFF_FFFC, sac_pkg::CMD_READ);
    // fill every way of set 5, then walk the LRU order
    for (int t = 1; t <= 4; t++) begin
      send_access(make_addr(24'(t), 4'd5, 2'(t)), sac_pkg::CMD_READ);
    end
    send_access(make_addr(24'd1, 4'd5, 2'd0), sac_pkg::CMD_READ);
    send_access(make_addr(24'd3, 4'd5, 2'd1), sac_pkg::CMD_WRITE);
    send_access(make_addr(24'd5, 4'd5, 2'd2), sac_pkg::CMD_READ);
    send_access(make_addr(24'd2, 4'd5, 2'd3), sac_pkg::CMD_READ);
    send_access(make_addr(24'd7, 4'd5, 2'd0), sac_pkg::CMD_READ);
    // evicts the dirty line
    send_access(make_addr(24'd8, 4'd5, 2'd0), sac_pkg::CMD_READ);
  endtask

  task automatic test_write_policies();
    wait_for_results();
    set_mode(1'b0, 1'b1, 1'b0);
    send_access(make_addr(24'd5, 4'd5, 2'd1), sac_pkg::CMD_WRITE);
    send_access(make_addr(24'd9, 4'd5, 2'd2), sac_pkg::CMD_WRITE);
    wait_for_results();
    set_mode(1'b0, 1'b0, 1'b0);
    send_access(make_addr(24'd10, 4'd5, 2'd3), sac_pkg::CMD_WRITE);
    send_access(make_addr(24'd10, 4'd5, 2'd3), sac_pkg::CMD_READ);
    wait_for_results();
    set_mode(1'b1, 1'b0, 1'b0);
    send_access(make_addr(24'd10, 4'd5, 2'd0), sac_pkg::CMD_WRITE);
    send_access(make_addr(24'd11, 4'd5, 2'd0), sac_pkg::CMD_WRITE);
  endtask

  task automatic test_random_replacement();
    wait_for_results();
    // the unused register index must change nothing
    cfg_put(CFG_SPARE, 1'b1);
    set_mode(1'b1, 1'b1, 1'b1);
    for (int t = 0; t < 5; t++) begin
      send_access(make_addr(24'h100 + 24'(t), 4'd9, 2'(t)), sac_pkg::CMD_READ);
    end
    wait_for_results();
    // back to LRU with ages left stale by random fills
    set_mode(1'b1, 1'b1, 1'b0);
    for (int t = 0; t < 3; t++) begin
      send_access(make_addr(24'h200 + 24'(t), 4'd9, 2'(t)), sac_pkg::CMD_READ);
    end
  endtask

  task automatic test_mixed_traffic();
    bit [2:0] mode_seq [8];
    logic [23:0] tag_pool [TAG_POOL];
    logic [3:0] hot_lines [2];
    logic [sac_pkg::ADDR_W-1:0] addr;
    int roll;
    mode_seq = '{3'b011, 3'b100, 3'b001, 3'b111, 3'b000, 3'b110, 3'b010, 3'b101};
    for (int phase = 0; phase < 8; phase++) begin
      wait_for_results();
      set_mode(mode_seq[phase][0], mode_seq[phase][1], mode_seq[phase][2]);
      gap_limit = (phase == 2 || phase == 6) ? 0 : GAP_MAX;
      stall_limit = (phase == 5 || phase == 6) ? 0 : GAP_MAX;
      for (int i = 0; i < TAG_POOL; i++) begin
        tag_pool[i] = 24'($urandom);
      end
      hot_lines[0] = 4'($urandom);
      hot_lines[1] = 4'($urandom);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          addr = make_addr(tag_pool[$urandom_range(TAG_POOL - 1)],
                           hot_lines[$urandom_range(1)], 2'($urandom));
        end else if (roll < 90) begin
          addr = make_addr(tag_pool[$urandom_range(TAG_POOL - 1)], 4'($urandom),
                           2'($urandom));
        end else begin
          addr = $urandom;
        end
        send_access(addr, $urandom_range(1) ? sac_pkg::CMD_WRITE : sac_pkg::CMD_READ);
        // now and then, at random, hold until every result word is back
        if ($urandom_range(199) == 0) begin
          wait_for_results();
        end
      end
    end
    gap_limit = GAP_MAX;
    stall_limit = GAP_MAX;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // wait out the clearing pass
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    test_lru_order();
    test_write_policies();
    test_random_replacement();
    test_mixed_traffic();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("** set_assoc_cache_tag_lru_unit: PASSED **");
    end else begin
      $display("** set_assoc_cache_tag_lru_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("** set_assoc_cache_tag_lru_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
hdl/sac_pkg.sv
hdl/sac_ram.sv
hdl/sac_update.sv
hdl/set_assoc_cache_tag_lru_unit.sv
bench/set_assoc_cache_tag_lru_unit_tb.sv
